// ----- rtl/rv32_subset_execute_unit_defines.svh -----
// Assertion macros used by the verification file of the execute unit.
`ifndef RV32_SUBSET_EXECUTE_UNIT_DEFINES_SVH
`define RV32_SUBSET_EXECUTE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define RV32SE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rv32se assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define RV32SE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rv32se assertion failed");

`endif

// ----- rtl/rv32se_pkg.sv -----
// Shared types, opcodes and widths of the RV32 subset execute unit.
package rv32se_pkg;

  localparam int unsigned RV32SE_MEM_BYTES = 65536;
  localparam int unsigned NREG             = 32;
  localparam int unsigned REG_IDX_W        = 5;
  localparam int unsigned IN_TDATA_W       = 64;
  localparam int unsigned OUT_TDATA_W      = 72;

  // Major opcodes
  localparam logic [6:0] OP_HALT   = 7'h00;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_PRINT  = 7'h0B;
  localparam logic [6:0] OP_INPUT  = 7'h0C;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_JAL    = 7'h6F;

  // funct3 codes
  localparam logic [2:0] F3_ADD = 3'd0;
  localparam logic [2:0] F3_SLL = 3'd1;
  localparam logic [2:0] F3_WORD = 3'd2;
  localparam logic [2:0] F3_XOR = 3'd4;
  localparam logic [2:0] F3_SR  = 3'd5;
  localparam logic [2:0] F3_OR  = 3'd6;
  localparam logic [2:0] F3_AND = 3'd7;
  localparam logic [2:0] F3_BEQ = 3'd0;
  localparam logic [2:0] F3_BNE = 3'd1;

  // Outcome of executing one instruction
  typedef struct packed {
    logic                 wb_en;
    logic [REG_IDX_W-1:0] wb_idx;
    logic [31:0]          wb_data;
    logic                 ld_en;
    logic                 st_en;
    logic [31:0]          mem_addr;
    logic [31:0]          st_data;
    logic [31:0]          pc_nxt;
    logic                 stop_nxt;
    logic                 unk;
    logic                 pvalid;
    logic [REG_IDX_W-1:0] preg;
    logic [31:0]          pval;
  } exec_res_t;

endpackage

// ----- rtl/rv32se_regfile.sv -----
// Register file: 32 x 32 bits, two registered read ports, one write port, reset-clear valid bits.
module rv32se_regfile import rv32se_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rd_en,
  input  logic [REG_IDX_W-1:0] ra,
  input  logic [REG_IDX_W-1:0] rb,
  input  logic                 we,
  input  logic [REG_IDX_W-1:0] wa,
  input  logic [31:0]          wd,
  output logic [31:0]          qa,
  output logic [31:0]          qb
);

  logic [31:0]     mem [NREG];
  logic [NREG-1:0] vld_r;
  logic [31:0]     qa_r;
  logic [31:0]     qb_r;
  logic            va_r;
  logic            vb_r;

  // Storage array: read before write on the same edge
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      qa_r <= mem[ra];
      qb_r <= mem[rb];
    end
  end

  // Valid bits: an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      va_r  <= 1'b0;
      vb_r  <= 1'b0;
    end else begin
      if (we) begin
        vld_r[wa] <= 1'b1;
      end
      if (rd_en) begin
        va_r <= vld_r[ra];
        vb_r <= vld_r[rb];
      end
    end
  end

  assign qa = va_r ? qa_r : 32'd0;
  assign qb = vb_r ? qb_r : 32'd0;

endmodule

// ----- rtl/rv32se_dmem.sv -----
// Data memory: four byte banks, big-endian unaligned word access, clearing sweep after reset.
module rv32se_dmem import rv32se_pkg::*; #(
  parameter int unsigned MEM_BYTES = RV32SE_MEM_BYTES
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         rd_en,
  input  logic                         we,
  input  logic [$clog2(MEM_BYTES)-1:0] addr,
  input  logic [31:0]                  wdata,
  output logic [31:0]                  rdata,
  output logic                         busy
);

  localparam int unsigned AW   = $clog2(MEM_BYTES);
  localparam int unsigned RW   = AW - 2;
  localparam int unsigned ROWS = MEM_BYTES / 4;

  logic [7:0]    mem [4][ROWS];
  logic [RW-1:0] brow [4];
  logic [7:0]    bwr  [4];
  logic [7:0]    bq_r [4];
  logic [1:0]    off_r;
  logic [RW-1:0] clr_row_r;
  logic          busy_r;

  // Per bank: which byte of the word lands here and on which row
  always_comb begin
    logic [1:0]    boff;
    logic [1:0]    bsh;
    logic [AW-1:0] baddr;
    for (int k = 0; k < 4; k++) begin
      boff    = 2'(k) - addr[1:0];
      bsh     = 2'd3 - boff;
      baddr   = addr + AW'(boff);
      brow[k] = baddr[AW-1:2];
      bwr[k]  = wdata[{bsh, 3'b000} +: 8];
    end
  end

  // Bank arrays: clear sweep has the write port while busy
  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      if (busy_r) begin
        mem[k][clr_row_r] <= 8'd0;
      end else if (we) begin
        mem[k][brow[k]] <= bwr[k];
      end
      if (rd_en) begin
        bq_r[k] <= mem[k][brow[k]];
      end
    end
    if (rd_en) begin
      off_r <= addr[1:0];
    end
  end

  // Clearing sweep, one row of all banks per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      clr_row_r <= '0;
    end else if (busy_r) begin
      clr_row_r <= clr_row_r + 1'b1;
      if (clr_row_r == RW'(ROWS - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Reassemble the word, most significant byte at the lowest address
  always_comb begin
    logic [1:0] bsel;
    rdata = '0;
    for (int i = 0; i < 4; i++) begin
      bsel = off_r + 2'(i);
      rdata[8*(3-i) +: 8] = bq_r[bsel];
    end
  end

  assign busy = busy_r;

endmodule

// ----- rtl/rv32se_exec.sv -----
// Execute stage logic: decode, ALU, branch resolution and next pc for one instruction.
module rv32se_exec import rv32se_pkg::*; (
  input  logic [31:0] instr,
  input  logic [31:0] in_val,
  input  logic [31:0] op_a,
  input  logic [31:0] op_b,
  input  logic [31:0] pc,
  input  logic        stopped,
  output exec_res_t   res
);

  logic [6:0]           opcode;
  logic [REG_IDX_W-1:0] rd;
  logic [2:0]           f3;
  logic [6:0]           f7;
  logic [4:0]           shi;
  logic [4:0]           shr;
  logic [31:0]          imm_i;
  logic [31:0]          imm_s;
  logic [31:0]          imm_b;
  logic [31:0]          imm_j;

  assign opcode = instr[6:0];
  assign rd     = instr[11:7];
  assign f3     = instr[14:12];
  assign f7     = instr[31:25];
  assign shi    = instr[24:20];
  assign shr    = op_b[4:0];
  assign imm_i  = {{20{instr[31]}}, instr[31:20]};
  assign imm_s  = {{20{instr[31]}}, instr[31:25], instr[11:7]};
  assign imm_b  = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
  assign imm_j  = {{11{instr[31]}}, instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};

  always_comb begin
    res          = '0;
    res.wb_idx   = rd;
    res.st_data  = op_b;
    res.pc_nxt   = pc + 32'd4;
    res.stop_nxt = stopped;
    if (stopped) begin
      // Stopped machine: hold everything
      res.pc_nxt = pc;
    end else begin
      unique case (opcode)
        OP_LOAD: begin
          res.mem_addr = op_a + imm_i;
          res.ld_en    = (f3 == F3_WORD);
          res.wb_en    = (f3 == F3_WORD);
        end
        OP_STORE: begin
          res.mem_addr = op_a + imm_s;
          res.st_en    = (f3 == F3_WORD);
        end
        OP_IMM: begin
          res.wb_en = 1'b1;
          unique case (f3)
            F3_ADD:  res.wb_data = op_a + imm_i;
            F3_XOR:  res.wb_data = op_a ^ imm_i;
            F3_OR:   res.wb_data = op_a | imm_i;
            F3_AND:  res.wb_data = op_a & imm_i;
            F3_SLL:  res.wb_data = op_a << shi;
            F3_SR:   res.wb_data = (f7 == 7'd0) ? (op_a >> shi)
                                                : $unsigned($signed(op_a) >>> shi);
            default: res.wb_en = 1'b0;
          endcase
        end
        OP_REG: begin
          res.wb_en = 1'b1;
          unique case (f3)
            F3_ADD:  res.wb_data = (f7 == 7'd0) ? (op_a + op_b) : (op_a - op_b);
            F3_SLL:  res.wb_data = op_a << shr;
            F3_XOR:  res.wb_data = op_a ^ op_b;
            F3_SR:   res.wb_data = (f7 == 7'd0) ? (op_a >> shr)
                                                : $unsigned($signed(op_a) >>> shr);
            F3_OR:   res.wb_data = op_a | op_b;
            F3_AND:  res.wb_data = op_a & op_b;
            default: res.wb_en = 1'b0;
          endcase
        end
        OP_BRANCH: begin
          if (((f3 == F3_BEQ) && (op_a == op_b)) || ((f3 == F3_BNE) && (op_a != op_b))) begin
            res.pc_nxt = pc + imm_b;
          end
        end
        OP_JAL: begin
          res.wb_en   = 1'b1;
          res.wb_data = pc + 32'd4;
          res.pc_nxt  = pc + imm_j;
        end
        OP_HALT: begin
          // Only the all-zero word halts; other words with this opcode just advance
          if (instr == 32'd0) begin
            res.stop_nxt = 1'b1;
            res.pc_nxt   = pc;
          end
        end
        OP_PRINT: begin
          // Port A was steered to rd for this opcode
          res.pvalid = 1'b1;
          res.preg   = rd;
          res.pval   = op_a;
        end
        OP_INPUT: begin
          res.wb_en   = 1'b1;
          res.wb_data = in_val;
        end
        default: begin
          res.stop_nxt = 1'b1;
          res.unk      = 1'b1;
          res.pc_nxt   = pc;
        end
      endcase
    end
  end

endmodule

// ----- rtl/rv32_subset_execute_unit.sv -----
// Top level of the RV32 subset execute unit: pipeline, forwarding and stream ports.
// The unit accepts one instruction per cycle and returns one result per instruction
// through the register file read on the accepting edge, execute with data memory access
// and write-back into the output register; the register file and data memory reads are
// both registered, and results of the two instructions ahead are forwarded, so
// back-to-back dependent instructions, loads included, never wait. While a result waits
// on out_tready the whole pipeline holds and in_tready is low. After reset the data
// memory is cleared one row of four bytes per cycle while in_tready stays low. MEM_BYTES
// must be a power of two; addresses wrap modulo it.
module rv32_subset_execute_unit import rv32se_pkg::*; #(
  parameter int unsigned MEM_BYTES = RV32SE_MEM_BYTES
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // in_tdata: [31:0] instruction, [63:32] input_value
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // out_tdata: [31:0] next_pc, [36:32] print_reg, [68:37] print_value, [69] halted,
  //            [70] unknown_opcode, [71] zero
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // out_tuser: [0] print_valid
  output logic                   out_tuser
);

  localparam int unsigned AW = $clog2(MEM_BYTES);

  logic                 adv;
  logic                 dm_busy;
  logic [REG_IDX_W-1:0] rf_ra;
  logic [31:0]          rf_qa;
  logic [31:0]          rf_qb;
  logic                 rf_we;
  logic [31:0]          s2_val;
  logic [31:0]          dm_word;
  logic [31:0]          op_a;
  logic [31:0]          op_b;
  logic [REG_IDX_W-1:0] s1_rb;
  exec_res_t            res;

  logic                 s1_vld_r;
  logic [31:0]          s1_ins_r;
  logic [31:0]          s1_inval_r;
  logic [REG_IDX_W-1:0] s1_ra_r;
  logic                 s2_vld_r;
  exec_res_t            s2_res_r;
  logic                 hold_vld_r;
  logic [REG_IDX_W-1:0] hold_idx_r;
  logic [31:0]          hold_data_r;
  logic [31:0]          pc_r;
  logic                 stopped_r;
  logic                 out_vld_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                 out_user_r;

  // Whole pipeline moves when the output register is free or being taken
  assign adv       = !out_vld_r || out_tready;
  assign in_tready = adv && !dm_busy;

  // PRINT reads rd through port A instead of rs1
  assign rf_ra = (in_tdata[6:0] == OP_PRINT) ? in_tdata[11:7] : in_tdata[19:15];
  assign s1_rb = s1_ins_r[24:20];

  // Write-back value: load data from memory or the executed result
  assign s2_val = s2_res_r.ld_en ? dm_word : s2_res_r.wb_data;
  assign rf_we  = adv && s2_vld_r && s2_res_r.wb_en;

  rv32se_regfile u_regfile (
    .clk   (clk),
    .rst_n (rst_n),
    .rd_en (adv),
    .ra    (rf_ra),
    .rb    (in_tdata[24:20]),
    .we    (rf_we),
    .wa    (s2_res_r.wb_idx),
    .wd    (s2_val),
    .qa    (rf_qa),
    .qb    (rf_qb)
  );

  // Forward from write-back stage first, then from the write made on the read edge
  always_comb begin
    if (s2_vld_r && s2_res_r.wb_en && (s2_res_r.wb_idx == s1_ra_r)) begin
      op_a = s2_val;
    end else if (hold_vld_r && (hold_idx_r == s1_ra_r)) begin
      op_a = hold_data_r;
    end else begin
      op_a = rf_qa;
    end
    if (s2_vld_r && s2_res_r.wb_en && (s2_res_r.wb_idx == s1_rb)) begin
      op_b = s2_val;
    end else if (hold_vld_r && (hold_idx_r == s1_rb)) begin
      op_b = hold_data_r;
    end else begin
      op_b = rf_qb;
    end
  end

  rv32se_exec u_exec (
    .instr   (s1_ins_r),
    .in_val  (s1_inval_r),
    .op_a    (op_a),
    .op_b    (op_b),
    .pc      (pc_r),
    .stopped (stopped_r),
    .res     (res)
  );

  rv32se_dmem #(
    .MEM_BYTES (MEM_BYTES)
  ) u_dmem (
    .clk   (clk),
    .rst_n (rst_n),
    .rd_en (adv),
    .we    (adv && s1_vld_r && res.st_en),
    .addr  (res.mem_addr[AW-1:0]),
    .wdata (res.st_data),
    .rdata (dm_word),
    .busy  (dm_busy)
  );

  // Control state: stage valids, pc, stop bit, forwarding hold
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r   <= 1'b0;
      s2_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      hold_vld_r <= 1'b0;
      pc_r       <= 32'd0;
      stopped_r  <= 1'b0;
    end else if (adv) begin
      s1_vld_r   <= in_tvalid && in_tready;
      s2_vld_r   <= s1_vld_r;
      out_vld_r  <= s2_vld_r;
      hold_vld_r <= s2_vld_r && s2_res_r.wb_en;
      if (s1_vld_r) begin
        pc_r      <= res.pc_nxt;
        stopped_r <= res.stop_nxt;
      end
    end
  end

  // Payload: advance with the pipeline
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ins_r    <= in_tdata[31:0];
      s1_inval_r  <= in_tdata[63:32];
      s1_ra_r     <= rf_ra;
      s2_res_r    <= res;
      hold_idx_r  <= s2_res_r.wb_idx;
      hold_data_r <= s2_val;
      out_data_r  <= {1'b0, s2_res_r.unk, s2_res_r.stop_nxt, s2_res_r.pval,
                      s2_res_r.preg, s2_res_r.pc_nxt};
      out_user_r  <= s2_res_r.pvalid;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ----- rtl/rv32se_checker.sv -----
// Port-level checker for the execute unit and its bind to the top level.
`include "rv32_subset_execute_unit_defines.svh"

module rv32se_checker import rv32se_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser
);

  // Hold a stalled result
  `RV32SE_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // Without a print request, print_reg and print_value read zero
  `RV32SE_ASSERT_IMP(a_no_print_zero, out_tvalid && !out_tuser, out_tdata[68:32] == '0)

  // An unknown opcode always stops the machine
  `RV32SE_ASSERT_IMP(a_unk_halts, out_tvalid && out_tdata[70], out_tdata[69])

  // A stopped machine never prints
  `RV32SE_ASSERT_IMP(a_halt_no_print, out_tvalid && out_tdata[69], !out_tuser)

endmodule

bind rv32_subset_execute_unit rv32se_checker u_rv32se_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
